// ===== src/rfgp_pkg.sv =====
// rfgp_pkg: shared types and constants for the raster font glyph placer.
// No dependencies; used by raster_font_glyph_placer.
package rfgp_pkg;

  typedef enum logic [1:0] {
    FUNC_WR_OFFSET  = 2'd0,
    FUNC_WR_SPACING = 2'd1,
    FUNC_START      = 2'd2,
    FUNC_PLACE      = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MODE_STRIKE = 2'd0,
    MODE_FIXED  = 2'd1,
    MODE_KERNED = 2'd2,
    MODE_FROZEN = 2'd3   // places like strike mode, pen does not move
  } mode_t;

  localparam logic [2:0] CFG_FONT_MODE     = 3'd0;
  localparam logic [2:0] CFG_FIRST_CODE    = 3'd1;
  localparam logic [2:0] CFG_LAST_CODE     = 3'd2;
  localparam logic [2:0] CFG_LEFT_PAD      = 3'd3;
  localparam logic [2:0] CFG_RIGHT_PAD     = 3'd4;
  localparam logic [2:0] CFG_FIXED_ADVANCE = 3'd5;
  localparam logic [2:0] CFG_STRIKE_BYTES  = 3'd6;
  localparam logic [2:0] CFG_ORIGIN_SHIFT  = 3'd7;

  localparam logic [7:0]  SPACE_CODE   = 8'd32;
  localparam logic [15:0] MISSING_MARK = 16'hFFFF;

endpackage

// ===== src/raster_font_glyph_placer.sv =====
// raster_font_glyph_placer: places bitmap font glyphs along a text line.
// Depends on rfgp_pkg and rfgp_ram.
//
//  channel | ports                                          | dir | handshake
//  --------+------------------------------------------------+-----+----------
//  in      | func, table_index, table_value, start_x, code  | in  | valid/ready
//  out     | glyph_valid, src_x, glyph_width, dest_x        | out | valid/ready
//  cfg     | we, index, wdata                               | in  | write enable
//
// One word per cycle sustained unless the output stalls or a reload is due.
// Each word is registered into stage 2, then its result into the output
// register. Stage 1 clamps the code and reads the spacing RAM and two offset
// RAM copies (glyph start and end); stage 2 forms the result and moves the pen.
// The last strike glyph's end sits in a register that follows table writes; a
// first or last code write drops input ready for one cycle while it is reloaded.
// Reset (sync, active low) clears pen, kern flag, pipeline valids and config.
// A stalled output holds the second stage; input ready otherwise drops only then.
module raster_font_glyph_placer #(
  parameter int OFFSET_ENTRIES = 257,
  parameter int CODE_ENTRIES   = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [8:0]         in_table_index,
  input  logic [15:0]        in_table_value,
  input  logic signed [15:0] in_start_x,
  input  logic [7:0]         in_char_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_glyph_valid,
  output logic [15:0]        out_src_x,
  output logic signed [16:0] out_glyph_width,
  output logic signed [15:0] out_dest_x,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int OW = $clog2(OFFSET_ENTRIES);
  localparam int CW = CODE_ENTRIES > 1 ? $clog2(CODE_ENTRIES) : 1;
  localparam logic [9:0] OFF_N  = 10'(OFFSET_ENTRIES);
  localparam logic [9:0] CODE_N = 10'(CODE_ENTRIES);

  // configuration
  rfgp_pkg::mode_t font_mode_r;
  logic [7:0]  first_code_r, last_code_r, fixed_advance_r;
  logic [7:0]  left_pad_r, right_pad_r;
  logic [12:0] strike_bytes_r;
  logic [15:0] origin_shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_mode_r     <= rfgp_pkg::MODE_STRIKE;
      first_code_r    <= 8'd32;
      last_code_r     <= 8'd126;
      left_pad_r      <= 8'd0;
      right_pad_r     <= 8'd0;
      fixed_advance_r <= 8'd8;
      strike_bytes_r  <= 13'd0;
      origin_shift_r  <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        rfgp_pkg::CFG_FONT_MODE:     font_mode_r     <= rfgp_pkg::mode_t'(cfg_wdata[1:0]);
        rfgp_pkg::CFG_FIRST_CODE:    first_code_r    <= cfg_wdata[7:0];
        rfgp_pkg::CFG_LAST_CODE:     last_code_r     <= cfg_wdata[7:0];
        rfgp_pkg::CFG_LEFT_PAD:      left_pad_r      <= cfg_wdata[7:0];
        rfgp_pkg::CFG_RIGHT_PAD:     right_pad_r     <= cfg_wdata[7:0];
        rfgp_pkg::CFG_FIXED_ADVANCE: fixed_advance_r <= cfg_wdata[7:0];
        rfgp_pkg::CFG_STRIKE_BYTES:  strike_bytes_r  <= cfg_wdata[12:0];
        rfgp_pkg::CFG_ORIGIN_SHIFT:  origin_shift_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // last glyph end moves with first/last code: reread it the cycle after
  logic reload_rd_r, reload_ld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_rd_r <= 1'b0;
      reload_ld_r <= 1'b0;
    end else begin
      reload_rd_r <= cfg_we && ((cfg_index == rfgp_pkg::CFG_FIRST_CODE)
                                || (cfg_index == rfgp_pkg::CFG_LAST_CODE));
      reload_ld_r <= reload_rd_r;
    end
  end

  // code reduction table, modulo CODE_ENTRIES, built at elaboration
  logic [CW-1:0] mod_lut [256];
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_lut[g] = CW'(g % CODE_ENTRIES);
  end

  // handshake
  logic b_v_r, b_adv, in_fire, out_valid_r;
  assign b_adv    = !out_valid_r || out_ready;
  assign in_ready = (!b_v_r || b_adv) && !reload_rd_r;
  assign in_fire  = in_valid && in_ready;

  // stage 1: clamp code, address tables
  rfgp_pkg::func_t in_fn;
  logic [7:0] code_c, idx8, last8;
  logic [8:0] diff9;
  logic [CW-1:0] k, lk;
  logic [8:0] k9, k1_9, l1_9;
  logic k_ok, k1_ok, l1_ok;

  always_comb begin
    in_fn  = rfgp_pkg::func_t'(in_func);
    code_c = (in_char_code > last_code_r) ? rfgp_pkg::SPACE_CODE : in_char_code;
    diff9  = {1'b0, code_c} - {1'b0, first_code_r};
    idx8   = diff9[8] ? (rfgp_pkg::SPACE_CODE - first_code_r) : diff9[7:0];
    last8  = last_code_r - first_code_r;
    k      = mod_lut[idx8];
    lk     = mod_lut[last8];
    k9     = 9'(k);
    k1_9   = 9'(k) + 9'd1;
    l1_9   = 9'(lk) + 9'd1;
    k_ok   = {1'b0, k9} < OFF_N;
    k1_ok  = {1'b0, k1_9} < OFF_N;
    l1_ok  = {1'b0, l1_9} < OFF_N;
  end

  logic off_we, sp_we;
  assign off_we = in_fire && (in_fn == rfgp_pkg::FUNC_WR_OFFSET)
                  && ({1'b0, in_table_index} < OFF_N);
  assign sp_we  = in_fire && (in_fn == rfgp_pkg::FUNC_WR_SPACING)
                  && ({1'b0, in_table_index} < CODE_N);

  logic [15:0] off_a, off_b, sp_rd;

  rfgp_ram #(.WIDTH(16), .DEPTH(OFFSET_ENTRIES)) u_off_cur (
    .clk(clk), .we(off_we), .waddr(OW'(in_table_index)), .wdata(in_table_value),
    .re(in_fire), .raddr(OW'(k9)), .rdata(off_a)
  );

  // glyph end; also serves the last glyph end reload
  rfgp_ram #(.WIDTH(16), .DEPTH(OFFSET_ENTRIES)) u_off_next (
    .clk(clk), .we(off_we), .waddr(OW'(in_table_index)), .wdata(in_table_value),
    .re(in_fire || reload_rd_r), .raddr(reload_rd_r ? OW'(l1_9) : OW'(k1_9)),
    .rdata(off_b)
  );

  rfgp_ram #(.WIDTH(16), .DEPTH(CODE_ENTRIES)) u_spacing (
    .clk(clk), .we(sp_we), .waddr(CW'(in_table_index)), .wdata(in_table_value),
    .re(in_fire), .raddr(k), .rdata(sp_rd)
  );

  // end of the last strike glyph, used by missing glyphs; a write wins over the reload
  logic [15:0] last_end_r;

  always_ff @(posedge clk) begin
    if (reload_ld_r) begin
      last_end_r <= off_b;
    end
    if (off_we && (in_table_index == l1_9)) begin
      last_end_r <= in_table_value;
    end
  end

  // stage 2 registers
  rfgp_pkg::func_t b_func_r;
  logic [15:0] b_start_r;
  logic b_k_ok_r, b_k1_ok_r, b_l1_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (in_fire) begin
      b_v_r <= 1'b1;
    end else if (b_adv) begin
      b_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_func_r  <= in_fn;
      b_start_r <= in_start_x;
      b_k_ok_r  <= k_ok;
      b_k1_ok_r <= k1_ok;
      b_l1_ok_r <= l1_ok;
    end
  end

  // stage 2: kern, placement, pen advance
  logic [15:0] pen_r, pen_nxt, pen_k, lp16, rp16, extra16, adv16;
  logic kern_r, kern_nxt, mark, missing;
  logic [15:0] sx, o1;
  logic [16:0] wid17;
  logic b_fire;

  assign b_fire = b_v_r && b_adv;

  always_comb begin
    lp16    = {{8{left_pad_r[7]}}, left_pad_r};
    rp16    = {{8{right_pad_r[7]}}, right_pad_r};
    extra16 = lp16 + rp16;
    mark    = (sp_rd == rfgp_pkg::MISSING_MARK);
    missing = (font_mode_r == rfgp_pkg::MODE_KERNED) && mark;
    pen_k   = (kern_r && !mark) ? pen_r + {{8{sp_rd[7]}}, sp_rd[7:0]} + rp16 : pen_r;
    o1      = b_k1_ok_r ? off_b : 16'd0;
    if (missing) begin
      sx    = b_l1_ok_r ? last_end_r : 16'd0;
      wid17 = {1'b0, strike_bytes_r, 3'b000} - {1'b0, sx};
    end else begin
      sx    = b_k_ok_r ? off_a : 16'd0;
      wid17 = {1'b0, o1} - {1'b0, sx};
    end
    kern_nxt = 1'b0;
    case (font_mode_r)
      rfgp_pkg::MODE_STRIKE: adv16 = wid17[15:0] + extra16;
      rfgp_pkg::MODE_FIXED:  adv16 = {8'd0, fixed_advance_r} + extra16;
      rfgp_pkg::MODE_KERNED: begin
        if (missing) begin
          adv16 = wid17[15:0] + extra16;
        end else begin
          adv16    = {{8{sp_rd[15]}}, sp_rd[15:8]};
          kern_nxt = 1'b1;
        end
      end
      default: adv16 = 16'd0;
    endcase
    case (b_func_r)
      rfgp_pkg::FUNC_START: pen_nxt = b_start_r + origin_shift_r + lp16;
      rfgp_pkg::FUNC_PLACE: pen_nxt = pen_k + adv16;
      default:              pen_nxt = pen_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r  <= 16'd0;
      kern_r <= 1'b0;
    end else if (b_fire) begin
      pen_r <= pen_nxt;
      if (b_func_r == rfgp_pkg::FUNC_PLACE) begin
        kern_r <= kern_nxt;
      end else if (b_func_r == rfgp_pkg::FUNC_START) begin
        kern_r <= 1'b0;
      end
    end
  end

  // output register
  logic        o_glyph_r;
  logic [15:0] o_src_r, o_dest_r;
  logic [16:0] o_wid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      if (b_func_r == rfgp_pkg::FUNC_PLACE) begin
        o_glyph_r <= 1'b1;
        o_src_r   <= sx;
        o_wid_r   <= wid17;
        o_dest_r  <= pen_k;
      end else begin
        o_glyph_r <= 1'b0;
        o_src_r   <= 16'd0;
        o_wid_r   <= 17'd0;
        o_dest_r  <= 16'd0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_glyph_valid = o_glyph_r;
  assign out_src_x       = o_src_r;
  assign out_glyph_width = o_wid_r;
  assign out_dest_x      = o_dest_r;

endmodule

// ===== src/rfgp_ram.sv =====
// rfgp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rfgp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
